FILE: sv/vpw_pkg.sv
// Shared types, constants and the divider step for the vertex projection block.
// Used by every module of vertex_project_to_window; depends on nothing.
package vpw_pkg;

    localparam int CoordW  = 32;   // Q16.16 coordinate width
    localparam int EntryW  = 16;   // Q4.12 matrix entry width
    localparam int ProdW   = 48;   // entry times coordinate
    localparam int PairW   = 49;
    localparam int ClipW   = 50;
    localparam int SumW    = 51;   // clip plus w
    localparam int ScaleW  = 13;
    localparam int OrigW   = 12;
    localparam int NumW    = 64;   // scaled numerator
    localparam int DenW    = 50;   // divisor magnitude
    localparam int QuotW   = 41;   // quotient bits, cap is 2^40
    localparam int CapSh   = 25;   // quotient width minus fraction shift
    localparam int FracSh  = 16;
    localparam int RegAddrW = 6;
    localparam int DataW    = 64;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_LEFT   = 3'd4,
        REG_BOTTOM = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } vpw_reg_t;

    typedef struct packed {
        logic [3:0][63:0]    rows;
        logic [OrigW-1:0]    left;
        logic [OrigW-1:0]    bottom;
        logic [ScaleW-1:0]   width;
        logic [ScaleW-1:0]   height;
    } vpw_cfg_t;

    typedef struct packed {
        logic             neg;
        logic             cap;
        logic [DenW-1:0]  rem;
        logic [QuotW-1:0] low;
        logic [QuotW-1:0] quot;
        logic [DenW-1:0]  den;
    } vpw_lane_t;

    typedef struct packed {
        logic                wzero;
        vpw_lane_t [2:0]     lane;
    } vpw_div_data_t;

    // One restoring division step: bring in the next dividend bit and subtract if it fits.
    function automatic vpw_lane_t div_step(vpw_lane_t a);
        vpw_lane_t      b;
        logic [DenW:0]  t;
        logic [DenW:0]  d;
        logic           ge;
        b  = a;
        t  = {a.rem, a.low[QuotW-1]};
        d  = {1'b0, a.den};
        ge = (t >= d);
        b.rem  = ge ? DenW'(t - d) : t[DenW-1:0];
        b.low  = {a.low[QuotW-2:0], 1'b0};
        b.quot = {a.quot[QuotW-2:0], ge};
        return b;
    endfunction

endpackage

FILE: sv/vpw_cfg.sv
// APB-style register file for the matrix rows and the viewport.
// Depends on vpw_pkg.
module vpw_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vpw_pkg::RegAddrW-1:0]  paddr,
    input  logic [vpw_pkg::DataW-1:0]     pwdata,
    output logic [vpw_pkg::DataW-1:0]     prdata,
    output logic                          pready,
    output vpw_pkg::vpw_cfg_t             cfg
);

    vpw_pkg::vpw_cfg_t cfg_reg;
    vpw_pkg::vpw_reg_t idx;
    logic              wr;

    assign idx    = vpw_pkg::vpw_reg_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows[0] <= 64'h0000_0000_0000_1000;
            cfg_reg.rows[1] <= 64'h0000_0000_1000_0000;
            cfg_reg.rows[2] <= 64'h0000_1000_0000_0000;
            cfg_reg.rows[3] <= 64'h1000_0000_0000_0000;
            cfg_reg.left    <= '0;
            cfg_reg.bottom  <= '0;
            cfg_reg.width   <= 13'd1024;
            cfg_reg.height  <= 13'd1024;
        end
        else if (wr)
        begin
            unique case (idx)
                vpw_pkg::REG_ROW0:   cfg_reg.rows[0] <= pwdata;
                vpw_pkg::REG_ROW1:   cfg_reg.rows[1] <= pwdata;
                vpw_pkg::REG_ROW2:   cfg_reg.rows[2] <= pwdata;
                vpw_pkg::REG_ROW3:   cfg_reg.rows[3] <= pwdata;
                vpw_pkg::REG_LEFT:   cfg_reg.left    <= pwdata[vpw_pkg::OrigW-1:0];
                vpw_pkg::REG_BOTTOM: cfg_reg.bottom  <= pwdata[vpw_pkg::OrigW-1:0];
                vpw_pkg::REG_WIDTH:  cfg_reg.width   <= pwdata[vpw_pkg::ScaleW-1:0];
                vpw_pkg::REG_HEIGHT: cfg_reg.height  <= pwdata[vpw_pkg::ScaleW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            vpw_pkg::REG_ROW0:   prdata = cfg_reg.rows[0];
            vpw_pkg::REG_ROW1:   prdata = cfg_reg.rows[1];
            vpw_pkg::REG_ROW2:   prdata = cfg_reg.rows[2];
            vpw_pkg::REG_ROW3:   prdata = cfg_reg.rows[3];
            vpw_pkg::REG_LEFT:   prdata = {52'b0, cfg_reg.left};
            vpw_pkg::REG_BOTTOM: prdata = {52'b0, cfg_reg.bottom};
            vpw_pkg::REG_WIDTH:  prdata = {51'b0, cfg_reg.width};
            vpw_pkg::REG_HEIGHT: prdata = {51'b0, cfg_reg.height};
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: sv/vpw_xform.sv
// Matrix transform, viewport scaling and divider setup, six register stages.
// Depends on vpw_pkg.
module vpw_xform (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [3*vpw_pkg::CoordW-1:0] in_data,
    input  vpw_pkg::vpw_cfg_t            cfg,
    output logic                         out_valid,
    output vpw_pkg::vpw_div_data_t       out_data
);

    localparam int PW = vpw_pkg::ProdW;

    logic [5:0] v_reg;

    logic signed [PW-1:0]                 prod_reg  [4][4];
    logic signed [vpw_pkg::PairW-1:0]     pair_reg  [4][2];
    logic signed [vpw_pkg::ClipW-1:0]     clip_reg  [4];
    logic signed [vpw_pkg::SumW-1:0]      cs_reg    [3];
    logic signed [vpw_pkg::ClipW-1:0]     w_reg;
    logic signed [vpw_pkg::ClipW-1:0]     w5_reg;
    logic signed [vpw_pkg::NumW-1:0]      n_reg     [3];
    logic                                 wz4_reg;
    logic                                 wz5_reg;
    vpw_pkg::vpw_div_data_t               div_reg;

    logic signed [vpw_pkg::CoordW-1:0] xin [3];
    logic [vpw_pkg::ScaleW-1:0]        scale [3];

    assign xin[0]   = in_data[31:0];
    assign xin[1]   = in_data[63:32];
    assign xin[2]   = in_data[95:64];
    assign scale[0] = cfg.width;
    assign scale[1] = cfg.height;
    assign scale[2] = 13'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PW'($signed(cfg.rows[r][16*c +: 16]) * xin[c]);
                end
                // Homogeneous coordinate 1.0 is 2^16 in Q16.16.
                prod_reg[r][3] <= PW'($signed({cfg.rows[r][63:48], 16'b0}));
                pair_reg[r][0] <= vpw_pkg::PairW'(prod_reg[r][0]) + vpw_pkg::PairW'(prod_reg[r][1]);
                pair_reg[r][1] <= vpw_pkg::PairW'(prod_reg[r][2]) + vpw_pkg::PairW'(prod_reg[r][3]);
                clip_reg[r]    <= vpw_pkg::ClipW'(pair_reg[r][0]) + vpw_pkg::ClipW'(pair_reg[r][1]);
            end
            for (int r = 0; r < 3; r++)
            begin
                cs_reg[r] <= vpw_pkg::SumW'(clip_reg[r]) + vpw_pkg::SumW'(clip_reg[3]);
                n_reg[r]  <= vpw_pkg::NumW'(cs_reg[r] * $signed({1'b0, scale[r]}));
            end
            w_reg   <= clip_reg[3];
            wz4_reg <= (clip_reg[3] == '0);
            w5_reg  <= w_reg;
            wz5_reg <= wz4_reg;
            div_reg <= stage6(n_reg, w5_reg, wz5_reg);
        end
    end

    function automatic vpw_pkg::vpw_div_data_t stage6(
        input logic signed [vpw_pkg::NumW-1:0]  n [3],
        input logic signed [vpw_pkg::ClipW-1:0] w,
        input logic                             wz
    );
        vpw_pkg::vpw_div_data_t     d;
        logic [vpw_pkg::NumW-1:0]   nm;
        logic [vpw_pkg::DenW-1:0]   wm;
        d.wzero = wz;
        wm = w[vpw_pkg::ClipW-1] ? vpw_pkg::DenW'(-w) : vpw_pkg::DenW'(w);
        for (int r = 0; r < 3; r++)
        begin
            nm = n[r][vpw_pkg::NumW-1] ? vpw_pkg::NumW'(-n[r]) : vpw_pkg::NumW'(n[r]);
            d.lane[r].neg  = n[r][vpw_pkg::NumW-1] ^ w[vpw_pkg::ClipW-1];
            // The quotient would overflow its 41 bits when nm >= wm * 2^25.
            d.lane[r].cap  = ({11'b0, nm} >= {wm, 25'b0});
            d.lane[r].rem  = {11'b0, nm[63:25]};
            d.lane[r].low  = {nm[24:0], 16'b0};
            d.lane[r].quot = '0;
            d.lane[r].den  = wm;
        end
        return d;
    endfunction

    assign out_valid = v_reg[5];
    assign out_data  = div_reg;

endmodule

FILE: sv/vpw_div.sv
// Pipelined restoring divider, one quotient bit per stage for all three lanes.
// Depends on vpw_pkg.
module vpw_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  vpw_pkg::vpw_div_data_t  in_data,
    output logic                    out_valid,
    output vpw_pkg::vpw_div_data_t  out_data
);

    localparam int N = vpw_pkg::QuotW;

    logic [N-1:0]           v_reg;
    vpw_pkg::vpw_div_data_t stage_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0].wzero <= in_data.wzero;
            for (int l = 0; l < 3; l++)
            begin
                stage_reg[0].lane[l] <= vpw_pkg::div_step(in_data.lane[l]);
            end
            for (int s = 1; s < N; s++)
            begin
                stage_reg[s].wzero <= stage_reg[s-1].wzero;
                for (int l = 0; l < 3; l++)
                begin
                    stage_reg[s].lane[l] <= vpw_pkg::div_step(stage_reg[s-1].lane[l]);
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_data  = stage_reg[N-1];

endmodule

FILE: sv/vpw_out.sv
// Rounding, sign, viewport offset and saturation into the output register.
// Depends on vpw_pkg.
module vpw_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  vpw_pkg::vpw_div_data_t        in_data,
    input  vpw_pkg::vpw_cfg_t             cfg,
    output logic                          out_valid,
    output logic [3*vpw_pkg::CoordW-1:0]  out_data,
    output logic                          out_ok
);

    logic                          valid_reg;
    logic [3*vpw_pkg::CoordW-1:0]  data_reg;
    logic                          ok_reg;

    function automatic logic [31:0] finish(vpw_pkg::vpw_lane_t a, logic [11:0] origin);
        logic [40:0]        q;
        logic [41:0]        inc;
        logic [40:0]        mag;
        logic signed [42:0] sv;
        q   = a.cap ? {1'b1, 40'b0} : a.quot;
        inc = {1'b0, q} + 42'd1;
        mag = inc[41:1];
        sv  = a.neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        sv  = sv + $signed({15'b0, origin, 16'b0});
        if (sv > 43'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (sv < -43'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return sv[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_data.wzero)
            begin
                data_reg <= '0;
                ok_reg   <= 1'b0;
            end
            else
            begin
                data_reg <= {finish(in_data.lane[2], 12'd0),
                             finish(in_data.lane[1], cfg.bottom),
                             finish(in_data.lane[0], cfg.left)};
                ok_reg   <= 1'b1;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_ok    = ok_reg;

endmodule

FILE: sv/vertex_project_to_window.sv
// Top level of the vertex projection pipeline.
// Depends on vpw_pkg, vpw_cfg, vpw_xform, vpw_div and vpw_out.
//
// Input beats on s_* carry one object-space vertex (x, y, z in Q16.16).
// Output beats on m_* carry window x, y and depth in Q16.16, with tuser
// set when clip w was nonzero; a zero w gives all-zero coordinates.
// The matrix rows and the viewport are to be written through the APB port
// only while the pipeline is empty; the block does not enforce this. The
// reset values are the identity and a 1024 by 1024 viewport at the origin.
// The pipeline has six transform stages, 41 divider stages (one quotient
// bit each) and the output register. One beat is accepted in every cycle
// unless the output stalls. The whole pipeline advances on a common enable:
// while an output beat waits and m_tready is low, every stage holds, and
// s_tready is low as well. Reset empties the pipeline at once.
module vertex_project_to_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [95:0]                  s_tdata,   // obj_x, obj_y, obj_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [95:0]                  m_tdata,   // win_x, win_y, win_depth
    output logic                         m_tuser,   // proj_ok
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vpw_pkg::RegAddrW-1:0] paddr,
    input  logic [vpw_pkg::DataW-1:0]    pwdata,
    output logic [vpw_pkg::DataW-1:0]    prdata,
    output logic                         pready
);

    vpw_pkg::vpw_cfg_t      cfg;
    vpw_pkg::vpw_div_data_t xf_data;
    vpw_pkg::vpw_div_data_t dv_data;
    logic                   xf_valid;
    logic                   dv_valid;
    logic                   en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    vpw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpw_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .cfg       (cfg),
        .out_valid (xf_valid),
        .out_data  (xf_data)
    );

    vpw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .in_data   (xf_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    vpw_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_data   (dv_data),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_ok    (m_tuser)
    );

endmodule

FILE: sv/vpw_checker.sv
// Port-level checks for vertex_project_to_window, bound to the top level.
// Depends on nothing but the top-level ports.
module vpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // A waiting output beat holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Input is taken exactly when the output side can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // A failed projection carries zero coordinates.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 96'b0)
        else $error("nonzero coordinates with proj_ok low");

    // Nothing leaves the pipeline in the cycle after reset.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind vertex_project_to_window vpw_checker u_vpw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/vpw_checker.sv
// Checker for vertex_project_to_window: mirrors the APB register file, predicts
// each output beat from accepted input beats and compares. Depends on vpw_pkg.
module tb_vpw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [vpw_pkg::RegAddrW-1:0] paddr,
    input  logic [vpw_pkg::DataW-1:0]    pwdata,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          misses
);

    typedef struct packed {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wd;
        logic        ok;
    } window_pt_t;

    logic [63:0]  mrow [4];
    logic [11:0]  org_x, org_y;
    logic [12:0]  size_x, size_y;
    window_pt_t   expected_pts [$];

    function automatic logic signed [63:0] row_dot(logic [63:0] r, logic signed [31:0] x,
                                                   logic signed [31:0] y, logic signed [31:0] z);
        logic signed [63:0] acc;
        acc = 64'(signed'(r[15:0])) * x + 64'(signed'(r[31:16])) * y
            + 64'(signed'(r[47:32])) * z + (64'(signed'(r[63:48])) <<< 16);
        return acc;
    endfunction

    // Rounded (c+w)*scale*2^15/w with the 2^40 quotient cap, plus the origin, then saturated.
    function automatic logic [31:0] to_window(logic signed [63:0] c, logic signed [63:0] w,
                                              logic [12:0] scale, logic [11:0] origin);
        logic signed [63:0] n, v;
        logic [63:0]        nm, wm, q, r, mag;
        logic               neg;
        n   = (c + w) * $signed({51'd0, scale});
        nm  = n[63] ? -n : n;
        wm  = w[63] ? -w : w;
        neg = n[63] != w[63];
        q = nm / wm;
        r = nm % wm;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        else
            for (int i = 0; i < 16; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= wm)
                begin
                    r = r - wm;
                    q[0] = 1'b1;
                end
                if (q > (64'd1 << 40))
                begin
                    q = 64'd1 << 40;
                    break;
                end
            end
        mag = (q + 64'd1) >> 1;
        v = neg ? -$signed(mag) : $signed(mag);
        v = v + ($signed({52'd0, origin}) <<< 16);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic window_pt_t project_vertex(logic [95:0] d);
        window_pt_t         p;
        logic signed [63:0] cx, cy, cz, cw;
        cx = row_dot(mrow[0], d[31:0], d[63:32], d[95:64]);
        cy = row_dot(mrow[1], d[31:0], d[63:32], d[95:64]);
        cz = row_dot(mrow[2], d[31:0], d[63:32], d[95:64]);
        cw = row_dot(mrow[3], d[31:0], d[63:32], d[95:64]);
        p = '0;
        if (cw != 0)
        begin
            p.wx = to_window(cx, cw, size_x, org_x);
            p.wy = to_window(cy, cw, size_y, org_y);
            p.wd = to_window(cz, cw, 13'd1, 12'd0);
            p.ok = 1'b1;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_pt_t e;
        if (!rst_n)
        begin
            mrow[0] <= 64'h1000;
            mrow[1] <= 64'h1000_0000;
            mrow[2] <= 64'h1000_0000_0000;
            mrow[3] <= 64'h1000_0000_0000_0000;
            org_x   <= '0;
            org_y   <= '0;
            size_x  <= 13'd1024;
            size_y  <= 13'd1024;
            errors  <= 0;
            checked <= 0;
            misses  <= 0;
            expected_pts.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (vpw_pkg::vpw_reg_t'(paddr[5:3]))
                    vpw_pkg::REG_ROW0:   mrow[0] <= pwdata;
                    vpw_pkg::REG_ROW1:   mrow[1] <= pwdata;
                    vpw_pkg::REG_ROW2:   mrow[2] <= pwdata;
                    vpw_pkg::REG_ROW3:   mrow[3] <= pwdata;
                    vpw_pkg::REG_LEFT:   org_x   <= pwdata[11:0];
                    vpw_pkg::REG_BOTTOM: org_y   <= pwdata[11:0];
                    vpw_pkg::REG_WIDTH:  size_x  <= pwdata[12:0];
                    vpw_pkg::REG_HEIGHT: size_y  <= pwdata[12:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                checked <= checked + 1;
                if (expected_pts.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10) $display("ERROR: unexpected output beat %h", m_tdata);
                end
                else
                begin
                    e = expected_pts.pop_front();
                    if ({m_tdata, m_tuser} !== {e.wd, e.wy, e.wx, e.ok})
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("ERROR: x %h/%h y %h/%h depth %h/%h ok %b/%b (exp/act)",
                                     e.wx, m_tdata[31:0], e.wy, m_tdata[63:32],
                                     e.wd, m_tdata[95:64], e.ok, m_tuser);
                    end
                    if (!e.ok) misses <= misses + 1;
                end
            end
            if (s_tvalid && s_tready) expected_pts.push_back(project_vertex(s_tdata));
        end
    end

    assign pending = expected_pts.size();
endmodule

FILE: tb/sv/tb_vertex_project_to_window.sv
// Testbench top for vertex_project_to_window: directed and random vertices under
// several matrix and viewport settings, bursty input and stalling output.
// Depends on vpw_pkg, the block and the checker tb_vpw_checker.
module tb_vertex_project_to_window;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0, m_tready = 1'b0;
    logic        s_tready, m_tvalid, m_tuser, pready;
    logic [95:0] s_tdata = '0;   // obj_x, obj_y, obj_z
    logic [95:0] m_tdata;        // win_x, win_y, win_depth
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [vpw_pkg::RegAddrW-1:0] paddr = '0;
    logic [vpw_pkg::DataW-1:0]    pwdata = '0, prdata;
    int errors, pending, checked, misses;
    int sent = 0;

    always #5 clk = ~clk;

    vertex_project_to_window dut (.*);
    tb_vpw_checker u_checker (.*);

    // Receiver stalls in its own rhythm: random stretches that are free or drop m_tready at random.
    initial
    begin
        int mode;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40))
            begin
                @(posedge clk);
                m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode - 1);
            end
        end
    end

    task automatic reg_write(vpw_pkg::vpw_reg_t idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= vpw_pkg::RegAddrW'(idx) << 3; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return 16'($urandom());
            1: return 16'h8000;
            2: return 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
        endcase
    endfunction

    // Holds s_tvalid across back-to-back beats; gaps only between bursts.
    task automatic send_vertex(logic [95:0] v, bit keep);
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_tready));
        sent++;
        if (!keep) s_tvalid <= 1'b0;
    endtask

    task automatic run_random(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > n) burst = n;
            for (int i = 0; i < burst; i++)
                send_vertex({rand_coord(), rand_coord(), rand_coord()}, i < burst - 1);
            n -= burst;
            repeat ($urandom_range(0, 5)) @(posedge clk);
        end
    endtask

    task automatic drain();
        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic load_matrix(bit extreme);
        for (int r = 0; r < 4; r++)
            reg_write(vpw_pkg::vpw_reg_t'(r), extreme ? {4{(r[0] ? 16'h8000 : 16'h7FFF)}}
                      : {rand_entry(), rand_entry(), rand_entry(), rand_entry()});
    endtask

    initial
    begin
        logic [31:0] edges [6] = '{32'h0, 32'h1_0000, 32'hFFFF_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Identity matrix: field extremes; origin maps to the viewport center.
        for (int i = 0; i < 6; i++)
            send_vertex({edges[(i + 2) % 6], edges[(i + 1) % 6], edges[i]}, 1'b0);
        send_vertex('0, 1'b0);
        drain();
        // A zero w row makes every projection fail.
        reg_write(vpw_pkg::REG_ROW3, 64'h0);
        for (int i = 0; i < 3; i++) send_vertex({rand_coord(), rand_coord(), rand_coord()}, 1'b0);
        drain();
        // w from x alone: x of zero fails, sign flips across it; extreme viewport.
        reg_write(vpw_pkg::REG_ROW3, 64'h1000);
        reg_write(vpw_pkg::REG_LEFT, 64'hFFF);
        reg_write(vpw_pkg::REG_BOTTOM, 64'hFFF);
        reg_write(vpw_pkg::REG_WIDTH, 64'd4096);
        reg_write(vpw_pkg::REG_HEIGHT, 64'd1);
        for (int i = 0; i < 6; i++) send_vertex({edges[5 - i], edges[i], edges[i]}, 1'b0);
        drain();
        // Out of range sizes: zero width pins x at origin, 8191 overflows.
        reg_write(vpw_pkg::REG_WIDTH, 64'd0);
        reg_write(vpw_pkg::REG_HEIGHT, 64'h1FFF);
        reg_write(vpw_pkg::REG_LEFT, 64'h0);
        run_random(8);
        drain();
        // Extreme matrix entries overflow and saturate.
        load_matrix(1'b1);
        run_random(8);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            load_matrix(1'b0);
            reg_write(vpw_pkg::REG_ROW3, {16'h1000, rand_entry() >> 4, rand_entry() >> 4,
                                          rand_entry() >> 4});
            reg_write(vpw_pkg::REG_LEFT, 64'($urandom_range(0, 4095)));
            reg_write(vpw_pkg::REG_BOTTOM, 64'($urandom_range(0, 4095)));
            reg_write(vpw_pkg::REG_WIDTH, 64'($urandom_range(1, 4096)));
            reg_write(vpw_pkg::REG_HEIGHT, 64'($urandom_range(1, 4096)));
            run_random(150);
            drain();
        end
        $display("Covered %0d vertices (%0d beats checked, %0d with zero w) over", sent,
                 checked, misses);
        $display("identity, degenerate, extreme and random matrices and viewports.");
        if (errors == 0)
            $display("vertex_project_to_window test passed");
        else
            $display("vertex_project_to_window test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("vertex_project_to_window test failed");
        $finish;
    end
endmodule

FILE: filelist.f
sv/vpw_pkg.sv
sv/vpw_cfg.sv
sv/vpw_xform.sv
sv/vpw_div.sv
sv/vpw_out.sv
sv/vertex_project_to_window.sv
sv/vpw_checker.sv
tb/sv/vpw_checker.sv
tb/sv/tb_vertex_project_to_window.sv
